@@ src/ascii_command_frame_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// ascii command frame parser assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASCII_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH
`define ASCII_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define ACFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acfp assertion failed");

// next-cycle implication
`define ACFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acfp assertion failed");

`endif

@@ src/acfp_pkg.sv @@
// ----------------------------------------------------------------------------
// acfp_pkg
// types and constants of the ascii command frame parser
// ----------------------------------------------------------------------------
package acfp_pkg;

  localparam int unsigned CountW = 6;

  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [3:0] JOINT_MAX = 4'd3;

  // register indexes
  localparam logic REG_BOARD_ADDRESS = 1'b0;

  typedef enum logic [2:0] {
    PH_ADDR,
    PH_JOINT,
    PH_OPCODE,
    PH_VSTART,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic              open;
    logic [CountW-1:0] count;
    phase_e            phase;
    logic [1:0]        joint;
    logic [7:0]        opcode;
    logic [15:0]       accum;
    logic              neg;
    logic              drop;
    logic              err;
  } chan_state_t;

  typedef struct packed {
    logic               channel;
    logic               status;
    logic [1:0]         joint;
    logic [7:0]         opcode;
    logic signed [15:0] value;
  } result_t;

endpackage

@@ src/acfp_step.sv @@
// ----------------------------------------------------------------------------
// acfp_step
// one-byte update of a channel's parse state and the command it completes
// ----------------------------------------------------------------------------
module acfp_step #(
  parameter int MAX_LEN = 32
) (
  input  acfp_pkg::chan_state_t st_i,
  input  logic                  channel_i,
  input  logic [7:0]            data_byte_i,
  input  logic [3:0]            board_address_i,
  output acfp_pkg::chan_state_t st_o,
  output logic                  res_valid_o,
  output acfp_pkg::result_t     res_o
);
  import acfp_pkg::*;

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_LEN);

  logic       is_digit;
  logic [3:0] digit;
  logic       handled;
  phase_e     ph;

  // ascii digits 0x30..0x39 carry their value in the low nibble
  assign is_digit = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  assign digit    = data_byte_i[3:0];

  // next state
  always_comb begin
    st_o    = st_i;
    handled = 1'b0;
    ph      = st_i.phase;
    if (data_byte_i == CH_OPEN) begin
      st_o       = '0;
      st_o.phase = PH_ADDR;
      st_o.open  = 1'b1;
      st_o.count = CountW'(1);
    end else if (st_i.open) begin
      if (st_i.count < MaxCount) begin
        st_o.count = st_i.count + CountW'(1);
        if (!st_i.drop && !st_i.err) begin
          // optional fields hand a non-digit on to the next field
          if (ph == PH_ADDR) begin
            if (is_digit) begin
              if (digit != board_address_i) st_o.drop = 1'b1;
              else                          st_o.phase = PH_JOINT;
              handled = 1'b1;
            end else begin
              ph = PH_JOINT;
            end
          end
          if (!handled && ph == PH_JOINT) begin
            if (is_digit) begin
              if (digit >= 4'd1 && digit <= JOINT_MAX) begin
                st_o.joint = digit[1:0];
                st_o.phase = PH_OPCODE;
              end else begin
                st_o.err = 1'b1;
              end
              handled = 1'b1;
            end else begin
              ph = PH_OPCODE;
            end
          end
          if (!handled) begin
            case (ph)
              PH_OPCODE: begin
                st_o.opcode = data_byte_i;
                st_o.phase  = PH_VSTART;
              end
              PH_VSTART: begin
                if (data_byte_i == CH_MINUS) begin
                  st_o.neg   = 1'b1;
                  st_o.phase = PH_DIGITS;
                end else if (is_digit) begin
                  st_o.accum = {12'd0, digit};
                  st_o.phase = PH_DIGITS;
                end else begin
                  st_o.phase = PH_DONE;
                end
              end
              PH_DIGITS: begin
                if (is_digit) begin
                  st_o.accum = (st_i.accum << 3) + (st_i.accum << 1) + {12'd0, digit};
                end else begin
                  st_o.phase = PH_DONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      if (data_byte_i == CH_CLOSE) st_o.open = 1'b0;
    end
  end

  // completed command; '>' never touches value, sign or flags
  always_comb begin
    res_valid_o   = st_i.open && (data_byte_i == CH_CLOSE) && !st_i.drop;
    res_o.channel = channel_i;
    res_o.status  = st_i.err;
    res_o.joint   = st_i.err ? 2'd0 : st_o.joint;
    res_o.opcode  = st_i.err ? 8'd0 : st_o.opcode;
    if (st_i.err)      res_o.value = '0;
    else if (st_i.neg) res_o.value = -$signed(st_i.accum);
    else               res_o.value = $signed(st_i.accum);
  end

endmodule

@@ src/acfp_out_skid.sv @@
// ----------------------------------------------------------------------------
// acfp_out_skid
// result register with one skid entry behind it
// ----------------------------------------------------------------------------
module acfp_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  acfp_pkg::result_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output acfp_pkg::result_t out_o
);
  import acfp_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = res_i;
      end
    end else if (!main_valid_q) begin
      main_valid_d = push_i;
      main_d       = res_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_o       = main_q;

endmodule

@@ src/ascii_command_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ascii_command_frame_parser_unit
// two-channel parser of '<' [addr] [joint] opcode [value] '>' command frames
// ----------------------------------------------------------------------------
// output: an accepted '>' word's command enters the result register, or the skid entry while a stalled result holds it
// throughput: one word per cycle while in_stall_o is low, set by the combinational per-channel update
// in_stall_o rises only while both the result and skid registers hold commands
// reset: both channels closed and cleared, board_address 0, no result pending
// ----------------------------------------------------------------------------
module ascii_command_frame_parser_unit #(
  parameter int MAX_LEN = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               channel_i,
  input  logic [7:0]         data_byte_i,
  // command output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               channel_out_o,
  output logic               status_o,
  output logic [1:0]         joint_o,
  output logic [7:0]         opcode_o,
  output logic signed [15:0] value_o
);
  import acfp_pkg::*;

  logic [3:0]  board_address_q;
  chan_state_t st_q [2];
  chan_state_t st_nxt;
  logic        in_acc;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  logic        skid_full;
  logic        cfg_wr;

  // apb port: one register, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_BOARD_ADDRESS) ? {28'd0, board_address_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_address_q <= 4'd0;
    end else if (cfg_wr && paddr[2] == REG_BOARD_ADDRESS) begin
      board_address_q <= pwdata[3:0];
    end
  end

  // a word is taken whenever the skid entry is free
  assign in_stall_o = skid_full;
  assign in_acc     = in_valid_i && !in_stall_o;

  // parse update of the addressed channel
  acfp_step #(
    .MAX_LEN(MAX_LEN)
  ) u_step (
    .st_i           (st_q[channel_i]),
    .channel_i      (channel_i),
    .data_byte_i    (data_byte_i),
    .board_address_i(board_address_q),
    .st_o           (st_nxt),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // per-channel parse registers, only the addressed channel moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= '0;
      st_q[1] <= '0;
    end else if (in_acc) begin
      st_q[channel_i] <= st_nxt;
    end
  end

  // result register plus skid entry so a stalled command does not block input
  acfp_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_acc && res_valid),
    .res_i      (res),
    .full_o     (skid_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_res)
  );

  assign channel_out_o = out_res.channel;
  assign status_o      = out_res.status;
  assign joint_o       = out_res.joint;
  assign opcode_o      = out_res.opcode;
  assign value_o       = out_res.value;

  // checks
  `include "ascii_command_frame_parser_unit_assert.svh"

  // an error command carries nothing but its channel and status
  `ACFP_ASSERT_NOW(a_err_payload_zero, out_valid_o && status_o, (joint_o == 2'd0) && (opcode_o == 8'd0) && (value_o == 16'sd0))
  // the skid entry is only used behind a held result
  `ACFP_ASSERT_NOW(a_skid_behind_main, skid_full, out_valid_o)
  // an accepted '<' opens a fresh frame on channel 0
  `ACFP_ASSERT_NEXT(a_open_ch0, in_acc && !channel_i && (data_byte_i == CH_OPEN), st_q[0].open && (st_q[0].count == CountW'(1)) && !st_q[0].drop && !st_q[0].err)
  // an accepted '>' on channel 1 closes the frame
  `ACFP_ASSERT_NEXT(a_close_ch1, in_acc && channel_i && (data_byte_i == CH_CLOSE), !st_q[1].open)

endmodule
